>>> sv/gcwd_pkg.sv
// gcwd_pkg: shared constants and types for the grid corner weight deposit block
// no dependencies; imported by grid_corner_weight_deposit
`default_nettype none

package gcwd_pkg;

    // fixed field widths
    localparam int COORD_W  = 32;
    localparam int CS_W     = 31;
    localparam int PTS_W    = 5;
    localparam int RIDX_W   = 12;
    localparam int WEIGHT_W = 48;
    localparam int STAT_W   = 2;
    localparam int SQ_W     = 49;
    localparam int CONTR_W  = 51;
    localparam int SUM_W    = 52;
    localparam int OFF_W    = 40;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 56;
    localparam int APB_AW   = 5;

    // function codes
    localparam logic FUNC_DEPOSIT = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POS_OUT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IDX_OUT = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_CS_RECIP  = 3'd4;
    localparam logic [2:0] REG_POINTS_X  = 3'd5;
    localparam logic [2:0] REG_POINTS_Y  = 3'd6;
    localparam logic [2:0] REG_POINTS_Z  = 3'd7;

    // saturation bounds of an accumulator
    localparam logic signed [SUM_W-1:0] W_MAX = SUM_W'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [SUM_W-1:0] W_MIN = -SUM_W'(64'sh8000_0000_0000);

    typedef logic signed [OFF_W-1:0]   off_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic signed [CONTR_W-1:0] contrib_t;

endpackage

`default_nettype wire

>>> sv/grid_corner_weight_deposit.sv
// grid_corner_weight_deposit: 3-D grid of weight accumulators with corner deposition
// depends on gcwd_pkg and gcwd_ram
// a stalled result word holds the block until it is taken; one word at a time, the next
// is accepted once the result word is registered; one shared 32x32 multiplier,
// eight read-modify-write passes on the grid ram
// after reset a clearing pass zeroes all GRID_POINTS entries, no item accepted
`default_nettype none

module grid_corner_weight_deposit #(
    parameter int MAX_POINTS_PER_AXIS = 16,
    parameter int GRID_POINTS         = 4096
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [gcwd_pkg::IN_DATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, read_index
    input  wire                          s_tuser,   // func
    // result stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [gcwd_pkg::OUT_DATA_W-1:0] m_tdata, // weight, status
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [gcwd_pkg::APB_AW-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import gcwd_pkg::*;

    localparam int ADDR_W = $clog2(GRID_POINTS);
    localparam int DW     = $clog2(MAX_POINTS_PER_AXIS + 1);
    localparam int LW0    = 3 * $clog2(MAX_POINTS_PER_AXIS) + 2;
    localparam int LW1    = (LW0 > 13) ? LW0 : 13;
    localparam int LIN_W  = (LW1 > ADDR_W + 1) ? LW1 : ADDR_W + 1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DIFF, ST_M0, ST_M1, ST_M2, ST_M3, ST_CHK,
        ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_OFFZ, ST_SQ, ST_TZ, ST_RMW,
        ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [COORD_W-1:0] origin_reg [3];
    logic [CS_W-1:0]    cs_reg;
    logic [CS_W-1:0]    recip_reg;
    logic [PTS_W-1:0]   pts_reg [3];

    // item and datapath registers
    logic [COORD_W-1:0]       pos_reg [3];
    logic [RIDX_W-1:0]        ridx_reg;
    logic signed [COORD_W:0]  d_reg [3];
    logic [31:0]              q_reg [3];
    logic [DW-1:0]            idx_reg [3];
    logic [LIN_W-1:0]         eyz_reg;
    logic [LIN_W-1:0]         base_reg;
    logic [WEIGHT_W-1:0]      diag_reg;
    off_t                     off_reg [6];
    sq_t                      sq_reg [6];
    contrib_t                 tz_reg [2];
    contrib_t                 contrib_reg;
    logic [ADDR_W-1:0]        waddr_reg;
    logic [3:0]               cnt_reg;
    logic [ADDR_W-1:0]        clr_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [WEIGHT_W-1:0]      weight_reg;
    logic [63:0]              prod_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    // effective point counts
    logic [DW-1:0] eff [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (32'(pts_reg[a]) > 32'(MAX_POINTS_PER_AXIS)) begin
                eff[a] = DW'(MAX_POINTS_PER_AXIS);
            end else begin
                eff[a] = DW'(pts_reg[a]);
            end
        end
    end

    // shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [OFF_W-1:0] abs_issue, abs_cap;
    always_comb begin
        abs_issue = off_reg[cnt_reg[2:0]] < 0 ? OFF_W'(-off_reg[cnt_reg[2:0]])
                                              : OFF_W'(off_reg[cnt_reg[2:0]]);
        abs_cap   = off_reg[cnt_reg[2:0] - 3'd1] < 0
                    ? OFF_W'(-off_reg[cnt_reg[2:0] - 3'd1])
                    : OFF_W'(off_reg[cnt_reg[2:0] - 3'd1]);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M0: begin mul_a = d_reg[0][31:0]; mul_b = 32'(recip_reg); end
            ST_M1: begin mul_a = d_reg[1][31:0]; mul_b = 32'(recip_reg); end
            ST_M2: begin mul_a = d_reg[2][31:0]; mul_b = 32'(recip_reg); end
            ST_M3, ST_RD0: begin mul_a = 32'(eff[2]); mul_b = 32'(eff[1]); end
            ST_CHK: begin mul_a = 32'(q_reg[0][DW-1:0]); mul_b = 32'(prod_reg[LIN_W-1:0]); end
            ST_M5: begin mul_a = 32'(q_reg[2][DW-1:0]); mul_b = 32'(eff[1]); end
            ST_M6: begin mul_a = 32'(cs_reg); mul_b = 32'(cs_reg); end
            ST_M7: begin mul_a = 32'(idx_reg[0]); mul_b = 32'(cs_reg); end
            ST_M8: begin mul_a = 32'(idx_reg[1]); mul_b = 32'(cs_reg); end
            ST_M9: begin mul_a = 32'(idx_reg[2]); mul_b = 32'(cs_reg); end
            ST_SQ: begin mul_a = abs_issue[31:0]; mul_b = abs_issue[31:0]; end
            ST_RD1: begin mul_a = 32'(eff[0]); mul_b = 32'(prod_reg[LIN_W-1:0]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // corner address and contribution for the corner in cnt_reg
    logic [LIN_W-1:0] li;
    contrib_t         contrib_c;
    always_comb begin
        li = base_reg + (cnt_reg[0] ? eyz_reg : '0)
           + (cnt_reg[2] ? LIN_W'(eff[1]) : '0) + LIN_W'(cnt_reg[1]);
        contrib_c = tz_reg[cnt_reg[2]]
                  - $signed({2'b00, sq_reg[{2'b00, cnt_reg[0]}]})
                  - $signed({2'b00, sq_reg[{2'b01, cnt_reg[1]}]});
    end

    // saturating accumulate
    logic signed [SUM_W-1:0] sum;
    logic [WEIGHT_W-1:0]     sat;
    logic [WEIGHT_W-1:0]     ram_rdata;
    always_comb begin
        sum = SUM_W'($signed(ram_rdata)) + SUM_W'(contrib_reg);
        if (sum > W_MAX) begin
            sat = W_MAX[WEIGHT_W-1:0];
        end else if (sum < W_MIN) begin
            sat = W_MIN[WEIGHT_W-1:0];
        end else begin
            sat = sum[WEIGHT_W-1:0];
        end
    end

    // grid ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WEIGHT_W-1:0] ram_wdata;
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = waddr_reg;
        ram_wdata = sat;
        ram_raddr = li[ADDR_W-1:0];
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_RMW && cnt_reg != 4'd0) begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_RD2) begin
            ram_raddr = ADDR_W'(LIN_W'(ridx_reg));
        end
    end

    gcwd_ram #(.WIDTH(WEIGHT_W), .DEPTH(GRID_POINTS)) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // deposit checks
    logic drop_chk;
    logic [LIN_W:0] far_idx;
    always_comb begin
        drop_chk = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (d_reg[a] < 0 || eff[a] < DW'(2)
                || {1'b0, q_reg[a]} + 33'd2 > 33'(eff[a])) begin
                drop_chk = 1'b1;
            end
        end
        far_idx = (LIN_W+1)'(base_reg) + (LIN_W+1)'(eyz_reg)
                + (LIN_W+1)'(eff[1]) + (LIN_W+1)'(1);
    end

    // configuration port
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[4:2])
            REG_ORIGIN_X:  prdata = origin_reg[0];
            REG_ORIGIN_Y:  prdata = origin_reg[1];
            REG_ORIGIN_Z:  prdata = origin_reg[2];
            REG_CELL_SIZE: prdata = 32'(cs_reg);
            REG_CS_RECIP:  prdata = 32'(recip_reg);
            REG_POINTS_X:  prdata = 32'(pts_reg[0]);
            REG_POINTS_Y:  prdata = 32'(pts_reg[1]);
            REG_POINTS_Z:  prdata = 32'(pts_reg[2]);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            cs_reg        <= CS_W'(65536);
            recip_reg     <= CS_W'(65536);
            pts_reg[0]    <= PTS_W'(16);
            pts_reg[1]    <= PTS_W'(16);
            pts_reg[2]    <= PTS_W'(16);
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_ORIGIN_X:  origin_reg[0] <= pwdata;
                REG_ORIGIN_Y:  origin_reg[1] <= pwdata;
                REG_ORIGIN_Z:  origin_reg[2] <= pwdata;
                REG_CELL_SIZE: cs_reg        <= pwdata[CS_W-1:0];
                REG_CS_RECIP:  recip_reg     <= pwdata[CS_W-1:0];
                REG_POINTS_X:  pts_reg[0]    <= pwdata[PTS_W-1:0];
                REG_POINTS_Y:  pts_reg[1]    <= pwdata[PTS_W-1:0];
                REG_POINTS_Z:  pts_reg[2]    <= pwdata[PTS_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier output register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // result word valid: set on a new word, cleared when taken
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(GRID_POINTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pos_reg[0] <= s_tdata[31:0];
                        pos_reg[1] <= s_tdata[63:32];
                        pos_reg[2] <= s_tdata[95:64];
                        ridx_reg   <= s_tdata[107:96];
                        weight_reg <= '0;
                        status_reg <= STAT_OK;
                        state_reg  <= (s_tuser == FUNC_READ) ? ST_RD0 : ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    for (int a = 0; a < 3; a++) begin
                        d_reg[a] <= $signed({pos_reg[a][31], pos_reg[a]})
                                  - $signed({origin_reg[a][31], origin_reg[a]});
                    end
                    state_reg <= ST_M0;
                end
                ST_M0: state_reg <= ST_M1;
                ST_M1: begin q_reg[0] <= prod_reg[63:32]; state_reg <= ST_M2; end
                ST_M2: begin q_reg[1] <= prod_reg[63:32]; state_reg <= ST_M3; end
                ST_M3: begin q_reg[2] <= prod_reg[63:32]; state_reg <= ST_CHK; end
                ST_CHK: begin
                    eyz_reg <= prod_reg[LIN_W-1:0];
                    for (int a = 0; a < 3; a++) begin
                        idx_reg[a] <= q_reg[a][DW-1:0];
                    end
                    if (drop_chk) begin
                        status_reg <= STAT_POS_OUT;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_M5;
                    end
                end
                ST_M5: begin base_reg <= prod_reg[LIN_W-1:0]; state_reg <= ST_M6; end
                ST_M6: begin
                    base_reg  <= base_reg + prod_reg[LIN_W-1:0] + LIN_W'(idx_reg[1]);
                    state_reg <= ST_M7;
                end
                ST_M7: begin
                    diag_reg <= 48'((prod_reg + {prod_reg[62:0], 1'b0}) >> 16);
                    if (far_idx >= (LIN_W+1)'(GRID_POINTS)) begin
                        status_reg <= STAT_POS_OUT;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_M8;
                    end
                end
                ST_M8, ST_M9, ST_OFFZ: begin
                    // corner offsets of the axis whose product just arrived
                    if (state_reg == ST_M8) begin
                        off_reg[0] <= OFF_W'(d_reg[0]) - $signed({1'b0, prod_reg[OFF_W-2:0]});
                        off_reg[1] <= OFF_W'(d_reg[0]) - $signed({1'b0, prod_reg[OFF_W-2:0]})
                                    - $signed(OFF_W'(cs_reg));
                        state_reg  <= ST_M9;
                    end else if (state_reg == ST_M9) begin
                        off_reg[2] <= OFF_W'(d_reg[1]) - $signed({1'b0, prod_reg[OFF_W-2:0]});
                        off_reg[3] <= OFF_W'(d_reg[1]) - $signed({1'b0, prod_reg[OFF_W-2:0]})
                                    - $signed(OFF_W'(cs_reg));
                        state_reg  <= ST_OFFZ;
                    end else begin
                        off_reg[4] <= OFF_W'(d_reg[2]) - $signed({1'b0, prod_reg[OFF_W-2:0]});
                        off_reg[5] <= OFF_W'(d_reg[2]) - $signed({1'b0, prod_reg[OFF_W-2:0]})
                                    - $signed(OFF_W'(cs_reg));
                        cnt_reg    <= '0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    // one square issued and the previous one captured each cycle
                    if (cnt_reg != 4'd0) begin
                        if (abs_cap[OFF_W-1:32] != '0) begin
                            sq_reg[cnt_reg[2:0] - 3'd1] <= SQ_W'(1) << 48;
                        end else begin
                            sq_reg[cnt_reg[2:0] - 3'd1] <= SQ_W'(prod_reg >> 16);
                        end
                    end
                    if (cnt_reg == 4'd6) begin
                        state_reg <= ST_TZ;
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_TZ: begin
                    tz_reg[0] <= $signed({3'b000, diag_reg}) - $signed({2'b00, sq_reg[4]});
                    tz_reg[1] <= $signed({3'b000, diag_reg}) - $signed({2'b00, sq_reg[5]});
                    cnt_reg   <= '0;
                    state_reg <= ST_RMW;
                end
                ST_RMW: begin
                    // read corner cnt, write back corner cnt-1
                    contrib_reg <= contrib_c;
                    waddr_reg   <= li[ADDR_W-1:0];
                    cnt_reg     <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd8) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_RD0: state_reg <= ST_RD1;
                ST_RD1: state_reg <= ST_RD2;
                ST_RD2: begin
                    if (LIN_W'(ridx_reg) >= prod_reg[LIN_W-1:0]
                        || LIN_W'(ridx_reg) >= LIN_W'(GRID_POINTS)) begin
                        status_reg <= STAT_IDX_OUT;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_RD3;
                    end
                end
                ST_RD3: begin
                    weight_reg <= ram_rdata;
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_data_reg  <= {6'b0, status_reg, weight_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/gcwd_ram.sv
// gcwd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module gcwd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking testbench for grid_corner_weight_deposit
// depends on gcwd_pkg and the block's rtl; predicts results with its own grid model
`timescale 1ns / 100ps

module tb;
    import gcwd_pkg::*;

    localparam int MAXP = 16;
    localparam int NPTS = 4096;

    // scoreboard: own copy of grid and registers, queue of predicted results
    class weight_scoreboard;
        logic signed [63:0] acc [NPTS];
        logic [31:0] org [3];
        logic [30:0] csize, recip;
        logic [4:0]  pts [3];
        logic [47:0] exp_weight [$];
        logic [1:0]  exp_status [$];
        int errors;

        function void clear();
            foreach (acc[i]) acc[i] = 0;
            foreach (org[i]) org[i] = 0;
            csize = 31'd65536;
            recip = 31'd65536;
            foreach (pts[i]) pts[i] = 5'd16;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_ORIGIN_X: org[0] = v;
                REG_ORIGIN_Y: org[1] = v;
                REG_ORIGIN_Z: org[2] = v;
                REG_CELL_SIZE: csize = v[30:0];
                REG_CS_RECIP: recip = v[30:0];
                REG_POINTS_X: pts[0] = v[4:0];
                REG_POINTS_Y: pts[1] = v[4:0];
                default: pts[2] = v[4:0];
            endcase
        endfunction

        function longint sq_floor(longint off);
            longint unsigned a;
            a = off < 0 ? -off : off;
            if (a >= 64'h1_0000_0000) return 64'sh1_0000_0000_0000;
            return longint'((a * a) >> 16);
        endfunction

        function void note_input(logic func, logic [31:0] p [3], logic [11:0] ridx);
            longint unsigned dim [3], cidx [3], li, cx, cy, cz;
            longint d [3];
            longint diag, contrib, s;
            logic [1:0] st;
            logic [47:0] w;
            st = STAT_OK;
            w = '0;
            foreach (dim[a]) dim[a] = pts[a] > MAXP ? MAXP : pts[a];
            if (func == FUNC_READ) begin
                if (ridx >= dim[0] * dim[1] * dim[2]) st = STAT_IDX_OUT;
                else w = acc[ridx][47:0];
            end else begin
                for (int a = 0; a < 3; a++) begin
                    if (st != STAT_OK) continue;
                    d[a] = longint'($signed(p[a])) - longint'($signed(org[a]));
                    if (d[a] < 0) begin
                        st = STAT_POS_OUT;
                        continue;
                    end
                    cidx[a] = (longint'(d[a]) * longint'({1'b0, recip})) >>> 32;
                    if (dim[a] < 2 || cidx[a] > dim[a] - 2) st = STAT_POS_OUT;
                end
                if (st == STAT_OK && (cidx[0] + 1) * dim[2] * dim[1]
                        + (cidx[2] + 1) * dim[1] + cidx[1] + 1 >= NPTS)
                    st = STAT_POS_OUT;
                if (st == STAT_OK) begin
                    diag = longint'((64'd3 * csize * csize) >> 16);
                    for (int k = 0; k < 8; k++) begin
                        cx = cidx[0] + k[0];
                        cy = cidx[1] + k[1];
                        cz = cidx[2] + k[2];
                        li = cx * dim[2] * dim[1] + cz * dim[1] + cy;
                        contrib = diag - sq_floor(d[0] - longint'(cx) * csize)
                            - sq_floor(d[1] - longint'(cy) * csize)
                            - sq_floor(d[2] - longint'(cz) * csize);
                        s = acc[li[11:0]] + contrib;
                        if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
                        if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
                        acc[li[11:0]] = s;
                    end
                end
            end
            exp_weight.push_back(w);
            exp_status.push_back(st);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            logic [47:0] w;
            logic [1:0] st;
            if (exp_weight.size() == 0) begin
                $error("unexpected result word %h", data);
                errors++;
                return;
            end
            w = exp_weight.pop_front();
            st = exp_status.pop_front();
            if (data[47:0] !== w) begin
                $error("weight: expected %h, actual %h", w, data[47:0]);
                errors++;
            end
            if (data[49:48] !== st) begin
                $error("status: expected %0d, actual %0d", st, data[49:48]);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    weight_scoreboard grid_sb;
    int hold_off = 0;   // receiver hold-off request in cycles
    bit rx_steady = 0;

    always #5 aclk = ~aclk;

    grid_corner_weight_deposit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // note every accepted input word and check every result word taken
    always @(posedge aclk) begin
        logic [31:0] p [3];
        if (aresetn && s_tvalid && s_tready) begin
            p[0] = s_tdata[31:0];
            p[1] = s_tdata[63:32];
            p[2] = s_tdata[95:64];
            grid_sb.note_input(s_tuser, p, s_tdata[107:96]);
        end
        if (aresetn && m_tvalid && m_tready) grid_sb.check_result(m_tdata);
    end

    // receiver stall pattern, with long hold-off on request
    initial begin
        int ph;
        ph = 0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_tready <= 0;
                hold_off--;
            end else if (rx_steady) begin
                m_tready <= 1;
            end else begin
                ph++;
                m_tready <= (ph % 7 < 4) || ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= APB_AW'(idx) << 2; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        grid_sb.set_reg(idx, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (grid_sb.exp_weight.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_word(logic func, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [11:0] ridx);
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser <= func;
        s_tdata <= {4'b0, ridx, z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic gap();
        s_tvalid <= 0;
    endtask

    // deposit near origin within the given span, a read, or random noise
    task automatic send_random(int unsigned span);
        logic [31:0] c [3];
        int r;
        r = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++)
            c[a] = grid_sb.org[a] + $urandom_range(0, span);
        if (r < 60) send_word(FUNC_DEPOSIT, c[0], c[1], c[2], 12'($urandom));
        else if (r < 90) send_word(FUNC_READ, $urandom, $urandom, $urandom,
                                   12'($urandom_range(0, 4095)));
        else send_word(FUNC_DEPOSIT, $urandom, $urandom, $urandom, 12'($urandom));
    endtask

    task automatic random_phase(int n, int unsigned span);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && n > 0; i++, n--) send_random(span);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge aclk);
                gap();
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
        @(negedge aclk);
        gap();
        drain();
    endtask

    initial begin
        grid_sb = new();
        grid_sb.clear();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: defaults, unit cells on a 16 cube
        rx_steady = 1;
        send_word(FUNC_DEPOSIT, 32'h0000_8000, 32'h0001_4000, 32'h0002_C000, 12'hFFF);
        send_word(FUNC_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_word(FUNC_DEPOSIT, 32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF, 12'h000);
        send_word(FUNC_DEPOSIT, 32'h000F_0000, 32'h0, 32'h0, 12'h0);
        send_word(FUNC_DEPOSIT, 32'h8000_0000, 32'h0, 32'h0, 12'h0);
        send_word(FUNC_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'h0);
        send_word(FUNC_DEPOSIT, 32'h0, 32'hFFFF_FFFF, 32'h0, 12'h0);
        send_word(FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h000);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'h001);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'hFFF);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'hEEE);
        @(negedge aclk);
        gap();
        drain();

        // big cells to drive saturation, extreme origin
        reg_write(REG_ORIGIN_X, 32'h8000_0000);
        reg_write(REG_ORIGIN_Y, 32'h8000_0000);
        reg_write(REG_ORIGIN_Z, 32'h8000_0000);
        reg_write(REG_CELL_SIZE, 32'h7FFF_FFFF);
        reg_write(REG_CS_RECIP, 32'h0000_0000);
        reg_write(REG_POINTS_X, 32'd2);
        reg_write(REG_POINTS_Y, 32'd2);
        reg_write(REG_POINTS_Z, 32'd2);
        for (int i = 0; i < 6; i++)
            send_word(FUNC_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 12'h0);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'd0);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'd7);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'd8);
        @(negedge aclk);
        gap();
        drain();

        // zero cell size, point counts above maximum and below two
        reg_write(REG_CELL_SIZE, 32'h0);
        reg_write(REG_CS_RECIP, 32'h7FFF_FFFF);
        reg_write(REG_POINTS_X, 32'd31);
        reg_write(REG_POINTS_Y, 32'd1);
        send_word(FUNC_DEPOSIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'h0);
        send_word(FUNC_READ, 32'h0, 32'h0, 32'h0, 12'd31);
        @(negedge aclk);
        gap();
        drain();
        reg_write(REG_POINTS_Y, 32'd0);
        send_word(FUNC_DEPOSIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'h0);
        @(negedge aclk);
        gap();
        drain();

        // long receiver hold-off while the sender keeps offering
        rx_steady = 0;
        reg_write(REG_ORIGIN_X, 32'h0);
        reg_write(REG_ORIGIN_Y, 32'h0);
        reg_write(REG_ORIGIN_Z, 32'h0);
        reg_write(REG_CELL_SIZE, 32'h0001_0000);
        reg_write(REG_CS_RECIP, 32'h0001_0000);
        reg_write(REG_POINTS_X, 32'd16);
        reg_write(REG_POINTS_Y, 32'd16);
        reg_write(REG_POINTS_Z, 32'd16);
        hold_off = 400;
        for (int i = 0; i < 20; i++) send_random(32'h0010_0000);
        @(negedge aclk);
        gap();
        drain();

        // random phases over several geometries
        random_phase(300, 32'h0010_0000);
        reg_write(REG_ORIGIN_X, 32'hFFF0_0000);
        reg_write(REG_ORIGIN_Y, 32'h0001_0000);
        reg_write(REG_ORIGIN_Z, 32'h7FF0_0000);
        reg_write(REG_CELL_SIZE, 32'h0000_4000);
        reg_write(REG_CS_RECIP, 32'h0004_0000);
        reg_write(REG_POINTS_X, 32'd5);
        reg_write(REG_POINTS_Y, 32'd9);
        reg_write(REG_POINTS_Z, 32'd3);
        random_phase(300, 32'h0002_8000);
        reg_write(REG_CELL_SIZE, 32'h0200_0000);
        reg_write(REG_CS_RECIP, 32'h0000_0080);
        reg_write(REG_POINTS_X, 32'd16);
        reg_write(REG_POINTS_Y, 32'd2);
        reg_write(REG_POINTS_Z, 32'd20);
        random_phase(250, 32'h7FFF_FFFF);
        reg_write(REG_CELL_SIZE, 32'h0001_8000);
        reg_write(REG_CS_RECIP, 32'h0000_AAAB);
        reg_write(REG_POINTS_Y, 32'd7);
        random_phase(250, 32'h0016_0000);

        if (grid_sb.errors == 0 && grid_sb.exp_weight.size() == 0) begin
            $display("grid_corner_weight_deposit regression: pass");
        end else begin
            $display("grid_corner_weight_deposit regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("grid_corner_weight_deposit regression: fail");
        $finish;
    end
endmodule
